// ===== hw/rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit: operation
// codes, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int WORK_W        = 64;
    localparam int CNT_W         = 6;
    localparam int KIND_W        = 3;

    // Operation codes carried on tuser.
    localparam logic [KIND_W-1:0] KIND_NORM = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEG  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INC  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CMP  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_INT  = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_INIT,
        S_GCD,
        S_DIV,
        S_STD_END,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMBINE,
        S_OUT
    } state_t;

    // Which fraction the reduction sequence is working on.
    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R,
        PH_I
    } phase_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ZERO,
        CMD_GCD_INIT,
        CMD_GCD_STEP,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_STORE_A,
        CMD_STORE_B,
        CMD_MUL0,
        CMD_MUL1,
        CMD_MUL2,
        CMD_COMBINE,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              zero;
        logic              gcd_eq;
        logic              div_last;
    } status_t;

endpackage

// ===== hw/rtl/rau_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dpath
// Datapath: operand registers, one shared multiplier, a binary gcd unit and
// a radix-2 divider that divides numerator and denominator together.
// ----------------------------------------------------------------------------
module rau_dpath #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rau_pkg::cmd_t               cmd,
    output rau_pkg::status_t            status,
    input  logic [rau_pkg::KIND_W-1:0]  in_kind,
    input  logic [rau_pkg::FIELD_W-1:0] in_a_num,
    input  logic [rau_pkg::FIELD_W-1:0] in_a_den,
    input  logic [rau_pkg::FIELD_W-1:0] in_b_num,
    input  logic [rau_pkg::FIELD_W-1:0] in_b_den,
    output logic [rau_pkg::WORK_W-1:0]  res_num,
    output logic [rau_pkg::WORK_W-2:0]  res_den,
    output logic                        greater
);

    localparam int W  = OPERAND_WIDTH;
    localparam int WW = rau_pkg::WORK_W;
    localparam int CW = rau_pkg::CNT_W;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    function automatic logic [WW-1:0] encode(input logic neg, input logic [WW-1:0] m);
        if (neg)
            encode = ~m + WW'(1);
        else if (m[WW-1])
            encode = {1'b0, {(WW-1){1'b1}}};
        else
            encode = m;
    endfunction

    logic [rau_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic          a_neg_reg, a_neg_next, b_neg_reg, b_neg_next;
    logic [W-1:0]  a_mag_reg, a_mag_next, a_den_reg, a_den_next;
    logic [W-1:0]  b_mag_reg, b_mag_next, b_den_reg, b_den_next;
    logic          neg_reg, neg_next, gt_reg, gt_next;
    logic [WW-1:0] num_reg, num_next, den_reg, den_next;
    logic [WW-1:0] x_reg, x_next, y_reg, y_next, dvs_reg, dvs_next;
    logic [WW-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [CW-1:0] k_reg, k_next, cnt_reg, cnt_next;
    logic [2*W-1:0] p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic [WW-1:0] rnum_reg, rnum_next;
    logic [WW-2:0] rden_reg, rden_next;
    logic          rgt_reg, rgt_next;

    logic [W-1:0]   mul_x, mul_y;
    logic [2*W-1:0] mul_p;
    logic [WW:0]    tn, td;
    logic [WW-1:0]  e0, e1, e2, sum, lhs, rhs;

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd)
            rau_pkg::CMD_MUL0:
            begin
                mul_x = a_mag_reg;
                mul_y = (kind_reg == rau_pkg::KIND_MUL) ? b_mag_reg : b_den_reg;
            end
            rau_pkg::CMD_MUL1:
            begin
                mul_x = b_mag_reg;
                mul_y = a_den_reg;
            end
            default:
            begin
                mul_x = a_den_reg;
                mul_y = b_den_reg;
            end
        endcase
        mul_p = mul_x * mul_y;
    end

    // Divider trial subtraction, and widened products for the combine step.
    always_comb
    begin
        tn  = {rn_reg, num_reg[WW-1]};
        td  = {rd_reg, den_reg[WW-1]};
        e0  = WW'(p0_reg);
        e1  = WW'(p1_reg);
        e2  = WW'(p2_reg);
        sum = e0 + e1;
        lhs = a_neg_reg ? (~e0 + WW'(1)) : e0;
        rhs = b_neg_reg ? (~e1 + WW'(1)) : e1;
    end

    // Next-value logic for every datapath register.
    always_comb
    begin
        kind_next = kind_reg;
        a_neg_next = a_neg_reg; a_mag_next = a_mag_reg; a_den_next = a_den_reg;
        b_neg_next = b_neg_reg; b_mag_next = b_mag_reg; b_den_next = b_den_reg;
        neg_next = neg_reg; gt_next = gt_reg;
        num_next = num_reg; den_next = den_reg;
        x_next = x_reg; y_next = y_reg; dvs_next = dvs_reg;
        rn_next = rn_reg; rd_next = rd_reg;
        k_next = k_reg; cnt_next = cnt_reg;
        p0_next = p0_reg; p1_next = p1_reg; p2_next = p2_reg;
        rnum_next = rnum_reg; rden_next = rden_reg; rgt_next = rgt_reg;

        case (cmd)
            rau_pkg::CMD_LOAD:
            begin
                kind_next  = in_kind;
                gt_next    = 1'b0;
                neg_next   = in_a_num[W-1] ^ in_a_den[W-1];
                num_next   = WW'(mag_of(in_a_num[W-1:0]));
                den_next   = WW'(mag_of(in_a_den[W-1:0]));
                b_neg_next = in_b_num[W-1] ^ in_b_den[W-1];
                b_mag_next = mag_of(in_b_num[W-1:0]);
                b_den_next = mag_of(in_b_den[W-1:0]);
            end
            rau_pkg::CMD_ZERO:
            begin
                neg_next = 1'b0;
                num_next = '0;
                den_next = WW'(1);
            end
            rau_pkg::CMD_GCD_INIT:
            begin
                x_next = num_reg;
                y_next = den_reg;
                k_next = '0;
            end
            // One binary gcd step: strip common or single factors of two,
            // otherwise subtract the smaller value from the larger.
            rau_pkg::CMD_GCD_STEP:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + CW'(1);
                end
                else if (!x_reg[0])
                    x_next = x_reg >> 1;
                else if (!y_reg[0])
                    y_next = y_reg >> 1;
                else if (x_reg > y_reg)
                    x_next = x_reg - y_reg;
                else
                    y_next = y_reg - x_reg;
            end
            rau_pkg::CMD_DIV_INIT:
            begin
                dvs_next = x_reg << k_reg;
                rn_next  = '0;
                rd_next  = '0;
                cnt_next = '1;
            end
            // Restoring division, one quotient bit of each dividend a cycle.
            rau_pkg::CMD_DIV_STEP:
            begin
                if (tn >= {1'b0, dvs_reg})
                begin
                    rn_next  = WW'(tn - {1'b0, dvs_reg});
                    num_next = {num_reg[WW-2:0], 1'b1};
                end
                else
                begin
                    rn_next  = WW'(tn);
                    num_next = {num_reg[WW-2:0], 1'b0};
                end
                if (td >= {1'b0, dvs_reg})
                begin
                    rd_next  = WW'(td - {1'b0, dvs_reg});
                    den_next = {den_reg[WW-2:0], 1'b1};
                end
                else
                begin
                    rd_next  = WW'(td);
                    den_next = {den_reg[WW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
            end
            rau_pkg::CMD_STORE_A:
            begin
                a_neg_next = neg_reg;
                a_mag_next = num_reg[W-1:0];
                a_den_next = den_reg[W-1:0];
                neg_next   = b_neg_reg;
                num_next   = WW'(b_mag_reg);
                den_next   = WW'(b_den_reg);
            end
            rau_pkg::CMD_STORE_B:
            begin
                b_neg_next = neg_reg;
                b_mag_next = num_reg[W-1:0];
                b_den_next = den_reg[W-1:0];
            end
            rau_pkg::CMD_MUL0: p0_next = mul_p;
            rau_pkg::CMD_MUL1: p1_next = mul_p;
            rau_pkg::CMD_MUL2: p2_next = mul_p;
            // Form the unreduced result of the operation.
            rau_pkg::CMD_COMBINE:
            begin
                neg_next = 1'b0;
                num_next = '0;
                den_next = WW'(1);
                case (kind_reg)
                    rau_pkg::KIND_NORM:
                    begin
                        neg_next = a_neg_reg;
                        num_next = WW'(a_mag_reg);
                        den_next = WW'(a_den_reg);
                    end
                    rau_pkg::KIND_ADD:
                    begin
                        den_next = e2;
                        if (a_neg_reg == b_neg_reg)
                        begin
                            neg_next = a_neg_reg;
                            num_next = sum;
                        end
                        else if (e0 >= e1)
                        begin
                            neg_next = a_neg_reg;
                            num_next = e0 - e1;
                        end
                        else
                        begin
                            neg_next = b_neg_reg;
                            num_next = e1 - e0;
                        end
                    end
                    rau_pkg::KIND_MUL:
                    begin
                        neg_next = a_neg_reg ^ b_neg_reg;
                        num_next = e0;
                        den_next = e2;
                    end
                    rau_pkg::KIND_NEG:
                    begin
                        neg_next = !a_neg_reg;
                        num_next = WW'(a_mag_reg);
                        den_next = WW'(a_den_reg);
                    end
                    rau_pkg::KIND_INC:
                    begin
                        den_next = WW'(a_den_reg);
                        if (!a_neg_reg)
                            num_next = WW'(a_mag_reg) + WW'(a_den_reg);
                        else if (a_mag_reg >= a_den_reg)
                        begin
                            neg_next = 1'b1;
                            num_next = WW'(a_mag_reg - a_den_reg);
                        end
                        else
                            num_next = WW'(a_den_reg - a_mag_reg);
                    end
                    rau_pkg::KIND_CMP:
                        gt_next = $signed(lhs) > $signed(rhs);
                    rau_pkg::KIND_INT:
                    begin
                        neg_next = a_neg_reg;
                        num_next = WW'(a_mag_reg);
                        dvs_next = WW'(a_den_reg);
                        rn_next  = '0;
                        rd_next  = '0;
                        cnt_next = '1;
                    end
                    default: ;
                endcase
            end
            rau_pkg::CMD_OUT:
            begin
                rgt_next = gt_reg;
                if (kind_reg == rau_pkg::KIND_INT)
                begin
                    rnum_next = encode(neg_reg && (num_reg != '0), num_reg);
                    rden_next = (WW-1)'(1);
                end
                else
                begin
                    rnum_next = encode(neg_reg, num_reg);
                    rden_next = den_reg[WW-2:0];
                end
            end
            default: ;
        endcase
    end

    // Control counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        a_neg_reg <= a_neg_next; a_mag_reg <= a_mag_next; a_den_reg <= a_den_next;
        b_neg_reg <= b_neg_next; b_mag_reg <= b_mag_next; b_den_reg <= b_den_next;
        neg_reg <= neg_next; gt_reg <= gt_next;
        num_reg <= num_next; den_reg <= den_next;
        x_reg <= x_next; y_reg <= y_next; dvs_reg <= dvs_next;
        rn_reg <= rn_next; rd_reg <= rd_next; k_reg <= k_next;
        p0_reg <= p0_next; p1_reg <= p1_next; p2_reg <= p2_next;
        rnum_reg <= rnum_next; rden_reg <= rden_next; rgt_reg <= rgt_next;
    end

    assign status.kind     = kind_reg;
    assign status.zero     = (num_reg == '0) || (den_reg == '0);
    assign status.gcd_eq   = (x_reg == y_reg);
    assign status.div_last = (cnt_reg == '0);
    assign res_num = rnum_reg;
    assign res_den = rden_reg;
    assign greater = rgt_reg;

    // A gcd step never sees a zero operand.
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == rau_pkg::CMD_GCD_STEP) |-> (x_reg != '0) && (y_reg != '0))
        else $error("gcd step on zero operand");

    // Divider partial remainders stay below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == rau_pkg::CMD_DIV_STEP) |-> (rn_reg < dvs_reg) && (rd_reg < dvs_reg))
        else $error("divider remainder out of range");

endmodule

// ===== hw/rtl/rau_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: sequences operand reduction, the operation and, where the kind
// needs it, result reduction or division; it owns the stream handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output rau_pkg::cmd_t    cmd,
    input  rau_pkg::status_t status
);

    rau_pkg::state_t state_reg, state_next;
    rau_pkg::phase_t phase_reg, phase_next;
    logic            ovalid_reg, ovalid_next;
    logic            out_free;

    assign out_free = !ovalid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            rau_pkg::S_IDLE:
                if (in_valid)
                begin
                    state_next = rau_pkg::S_GCD_INIT;
                    phase_next = rau_pkg::PH_A;
                end
            rau_pkg::S_GCD_INIT:
                state_next = status.zero ? rau_pkg::S_STD_END : rau_pkg::S_GCD;
            rau_pkg::S_GCD:
                if (status.gcd_eq)
                    state_next = rau_pkg::S_DIV;
            rau_pkg::S_DIV:
                if (status.div_last)
                    state_next = rau_pkg::S_STD_END;
            rau_pkg::S_STD_END:
                case (phase_reg)
                    rau_pkg::PH_A:
                    begin
                        state_next = rau_pkg::S_GCD_INIT;
                        phase_next = rau_pkg::PH_B;
                    end
                    rau_pkg::PH_B: state_next = rau_pkg::S_MUL0;
                    default:       state_next = rau_pkg::S_OUT;
                endcase
            rau_pkg::S_MUL0: state_next = rau_pkg::S_MUL1;
            rau_pkg::S_MUL1: state_next = rau_pkg::S_MUL2;
            rau_pkg::S_MUL2: state_next = rau_pkg::S_COMBINE;
            rau_pkg::S_COMBINE:
                if (status.kind == rau_pkg::KIND_INT)
                begin
                    state_next = rau_pkg::S_DIV;
                    phase_next = rau_pkg::PH_I;
                end
                else if (status.kind == rau_pkg::KIND_CMP || status.kind > rau_pkg::KIND_INT)
                    state_next = rau_pkg::S_OUT;
                else
                begin
                    state_next = rau_pkg::S_GCD_INIT;
                    phase_next = rau_pkg::PH_R;
                end
            rau_pkg::S_OUT:
                if (out_free)
                    state_next = rau_pkg::S_IDLE;
            default: state_next = rau_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath and handshake outputs.
    always_comb
    begin
        cmd      = rau_pkg::CMD_NONE;
        in_ready = 1'b0;
        case (state_reg)
            rau_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd = rau_pkg::CMD_LOAD;
            end
            rau_pkg::S_GCD_INIT:
                cmd = status.zero ? rau_pkg::CMD_ZERO : rau_pkg::CMD_GCD_INIT;
            rau_pkg::S_GCD:
                cmd = status.gcd_eq ? rau_pkg::CMD_DIV_INIT : rau_pkg::CMD_GCD_STEP;
            rau_pkg::S_DIV:
                cmd = rau_pkg::CMD_DIV_STEP;
            rau_pkg::S_STD_END:
                case (phase_reg)
                    rau_pkg::PH_A: cmd = rau_pkg::CMD_STORE_A;
                    rau_pkg::PH_B: cmd = rau_pkg::CMD_STORE_B;
                    default:       cmd = rau_pkg::CMD_NONE;
                endcase
            rau_pkg::S_MUL0:    cmd = rau_pkg::CMD_MUL0;
            rau_pkg::S_MUL1:    cmd = rau_pkg::CMD_MUL1;
            rau_pkg::S_MUL2:    cmd = rau_pkg::CMD_MUL2;
            rau_pkg::S_COMBINE: cmd = rau_pkg::CMD_COMBINE;
            rau_pkg::S_OUT:
                if (out_free)
                    cmd = rau_pkg::CMD_OUT;
            default: cmd = rau_pkg::CMD_NONE;
        endcase
    end

    // Output valid flag: set when a result is loaded, cleared when taken.
    always_comb
    begin
        if (cmd == rau_pkg::CMD_OUT)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rau_pkg::S_IDLE;
            phase_reg  <= rau_pkg::PH_A;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    // An accepted item blocks further input on the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while busy");

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == rau_pkg::CMD_OUT) |-> (!ovalid_reg || out_ready))
        else $error("pending result overwritten");

endmodule

// ===== hw/rtl/rational_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit
// Arithmetic on signed fractions with results reduced by the gcd.
//
// Channel  Signals         Contents
// input    s_axis_*        tuser: kind; tdata: a_num, a_den, b_num, b_den
// output   m_axis_*        tdata: res_num, res_den, greater
//
// Each fraction (a, b, then the result) is reduced by a binary gcd and a
// division of numerator and denominator by that gcd. The gcd loop on the
// 64-bit result dominates the time an item takes. Reset clears the
// controller and the divider counter. Input is taken again as soon as the
// result sits in the output register, even while that result is stalled.
// ----------------------------------------------------------------------------
module rational_arith_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic [7:0]   s_axis_tuser,  // kind, zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // res_num, res_den, greater
);

    rau_pkg::cmd_t    cmd;
    rau_pkg::status_t status;
    logic [63:0]      res_num;
    logic [62:0]      res_den;
    logic             greater;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    rau_dpath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_kind  (s_axis_tuser[2:0]),
        .in_a_num (s_axis_tdata[31:0]),
        .in_a_den (s_axis_tdata[63:32]),
        .in_b_num (s_axis_tdata[95:64]),
        .in_b_den (s_axis_tdata[127:96]),
        .res_num  (res_num),
        .res_den  (res_den),
        .greater  (greater)
    );

    assign m_axis_tdata = {greater, res_den, res_num};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rational arithmetic unit. A short table of
// hand-picked items comes first, followed by random fractions of mixed
// magnitude. Every result is checked against the typed answer of its row
// or a fraction calculator run alongside; both stream sides pause at random.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic               neg;
        logic [63:0]        mag;
        logic [63:0]        den;
    } fraction_t;

    typedef struct {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic               greater;
    } answer_t;

    typedef struct {
        logic [rau_pkg::KIND_W-1:0] kind;
        logic [31:0]        a_num;
        logic [31:0]        a_den;
        logic [31:0]        b_num;
        logic [31:0]        b_den;
        logic               typed;
        answer_t            ans;
    } row_t;

    localparam int IDLE_LIMIT = 6000;
    localparam int RANDOM_ITEMS = 1400;
    localparam logic [rau_pkg::KIND_W-1:0] KIND_BAD = 3'd7;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [7:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    answer_t answers_due[$];
    row_t    table_rows[$];
    int      errors;
    int      idle_cycles;
    int      stall_left;
    logic    quiet;

    rational_arith_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Reduce a sign/magnitude pair to lowest terms with a positive denominator.
    function automatic fraction_t reduce(logic nneg, logic [63:0] nmag,
                                         logic dneg, logic [63:0] dmag);
        fraction_t f;
        logic [63:0] g;
        if (nmag == 0 || dmag == 0)
        begin
            f.neg = 1'b0;
            f.mag = 64'd1 - 64'd1;
            f.den = 64'd1;
            return f;
        end
        g = euclid_gcd(nmag, dmag);
        f.neg = nneg ^ dneg;
        f.mag = nmag / g;
        f.den = dmag / g;
        return f;
    endfunction

    function automatic fraction_t load_fraction(logic [31:0] n, logic [31:0] d);
        logic [63:0] nm;
        logic [63:0] dm;
        nm = n[31] ? (64'd1 << 32) - {32'd0, n} : {32'd0, n};
        dm = d[31] ? (64'd1 << 32) - {32'd0, d} : {32'd0, d};
        return reduce(n[31], nm, d[31], dm);
    endfunction

    function automatic logic signed [63:0] signed_product(logic neg, logic [63:0] x,
                                                          logic [63:0] y);
        logic signed [63:0] v;
        v = x * y;
        return neg ? -v : v;
    endfunction

    // Expected result of one item.
    function automatic answer_t compute_answer(row_t it);
        fraction_t a;
        fraction_t b;
        fraction_t r;
        logic [63:0] m1;
        logic [63:0] m2;
        answer_t ans;
        a = load_fraction(it.a_num, it.a_den);
        b = load_fraction(it.b_num, it.b_den);
        r.neg = 1'b0;
        r.mag = '0;
        r.den = 64'd1;
        ans.greater = 1'b0;
        m1 = a.mag * b.den;
        m2 = b.mag * a.den;
        case (it.kind)
            rau_pkg::KIND_NORM: r = a;
            rau_pkg::KIND_ADD:
            begin
                if (a.neg == b.neg)
                    r = reduce(a.neg, m1 + m2, 1'b0, a.den * b.den);
                else if (m1 >= m2)
                    r = reduce(a.neg, m1 - m2, 1'b0, a.den * b.den);
                else
                    r = reduce(b.neg, m2 - m1, 1'b0, a.den * b.den);
            end
            rau_pkg::KIND_MUL:
                r = reduce(a.neg ^ b.neg, a.mag * b.mag, 1'b0, a.den * b.den);
            rau_pkg::KIND_NEG: r = reduce(!a.neg, a.mag, 1'b0, a.den);
            rau_pkg::KIND_INC:
            begin
                if (!a.neg)
                    r = reduce(1'b0, a.mag + a.den, 1'b0, a.den);
                else if (a.mag >= a.den)
                    r = reduce(1'b1, a.mag - a.den, 1'b0, a.den);
                else
                    r = reduce(1'b0, a.den - a.mag, 1'b0, a.den);
            end
            rau_pkg::KIND_CMP:
                ans.greater = signed_product(a.neg, a.mag, b.den) >
                              signed_product(b.neg, b.mag, a.den);
            rau_pkg::KIND_INT:
            begin
                r.mag = a.mag / a.den;
                r.neg = (r.mag != 0) ? a.neg : 1'b0;
            end
            default: ;
        endcase
        if (r.neg)
            ans.num = -r.mag;
        else if (r.mag > 64'h7fff_ffff_ffff_ffff)
            ans.num = 64'h7fff_ffff_ffff_ffff;
        else
            ans.num = r.mag;
        ans.den = r.den[62:0];
        return ans;
    endfunction

    function automatic row_t make_row(logic [rau_pkg::KIND_W-1:0] kind, logic [31:0] an,
                                      logic [31:0] ad, logic [31:0] bn,
                                      logic [31:0] bd, logic typed,
                                      logic signed [63:0] num, logic [62:0] den,
                                      logic greater);
        row_t it;
        it.kind = kind;
        it.a_num = an;
        it.a_den = ad;
        it.b_num = bn;
        it.b_den = bd;
        it.typed = typed;
        it.ans.num = num;
        it.ans.den = den;
        it.ans.greater = greater;
        return it;
    endfunction

    // Random operand value of mixed size, kept inside the legal range.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            v = $urandom_range(0, 40) - 20;
        else if (r < 55)
            v = ($urandom_range(0, 12) - 6) * $urandom_range(1, 5000);
        else if (r < 65)
            v = $urandom_range(0, 65535) - 32768;
        else if (r < 90)
            v = $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0: v = 32'h7fff_ffff;
                1: v = 32'h8000_0001;
                2: v = 32'h0000_0001;
                default: v = 32'hffff_ffff;
            endcase
        end
        if (v == 32'h8000_0000)
            v = 32'h8000_0001;
        return v;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Send one item and record its expected result on acceptance.
    task automatic send_item(row_t it);
        int gap;
        gap = gap_length();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {5'd0, it.kind};
        s_axis_tdata  <= {it.b_den, it.b_num, it.a_den, it.a_num};
        do
            @(posedge clk);
        while (!s_axis_tready);
        answers_due.push_back(it.typed ? it.ans : compute_answer(it));
    endtask

    // Output side: random stalls and result checking.
    always @(posedge clk)
    begin
        answer_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (answers_due.size() == 0)
                report_mismatch("unexpected item", m_axis_tdata[63:0], 64'd0);
            else
            begin
                want = answers_due.pop_front();
                if (m_axis_tdata[63:0] !== want.num)
                    report_mismatch("res_num", m_axis_tdata[63:0], want.num);
                if (m_axis_tdata[126:64] !== want.den)
                    report_mismatch("res_den", {1'b0, m_axis_tdata[126:64]}, {1'b0, want.den});
                if (m_axis_tdata[127] !== want.greater)
                    report_mismatch("greater", {63'd0, m_axis_tdata[127]},
                                    {63'd0, want.greater});
            end
        end
        if (stall_left != 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left = gap_length();
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL rational_arith_unit");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        row_t it;
        errors = 0;
        idle_cycles = 0;
        stall_left = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;

        // Directed items; typed answers where they are obvious.
        table_rows.push_back(make_row(rau_pkg::KIND_NORM, 32'd0, 32'd5, 0, 1,
                                      1, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_NORM, 32'd7, 32'd0, 0, 1,
                                      1, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_NORM, 32'd6, -32'sd4, 0, 1,
                                      1, -3, 2, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_NORM, 32'h7fff_ffff, 32'h8000_0001,
                                      0, 1, 1, -1, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3,
                                      1, 5, 6, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_ADD, 32'h7fff_ffff, 32'h7fff_fffe,
                                      32'h8000_0001, 32'h7fff_fffd, 0, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_ADD, 32'd1, 32'd3, -32'sd1, 32'd3,
                                      1, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_MUL, 32'h7fff_ffff, 32'd1,
                                      32'h7fff_ffff, 32'd1, 0, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_MUL, 32'h8000_0001, 32'h7fff_fffe,
                                      32'd1, 32'h7fff_fffd, 0, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_MUL, 32'd2, 32'd3, 32'd3, -32'sd2,
                                      1, -1, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_NEG, 32'd3, 32'd0, 0, 1,
                                      1, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_NEG, -32'sd4, 32'd6, 0, 1,
                                      1, 2, 3, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_INC, -32'sd1, 32'd2, 0, 1,
                                      1, 1, 2, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_INC, -32'sd5, 32'd2, 0, 1,
                                      1, -3, 2, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_INC, 32'h7fff_ffff, 32'd1, 0, 1,
                                      0, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_CMP, 32'd1, 32'd2, 32'd1, 32'd3,
                                      1, 0, 1, 1));
        table_rows.push_back(make_row(rau_pkg::KIND_CMP, 32'd1, 32'd3, 32'd2, 32'd6,
                                      1, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_CMP, 32'h8000_0001, 32'd1,
                                      32'h7fff_ffff, 32'h7fff_fffe, 1, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_INT, -32'sd7, 32'd2, 0, 1,
                                      1, -3, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_INT, 32'd1, 32'd3, 0, 1,
                                      1, 0, 1, 0));
        table_rows.push_back(make_row(rau_pkg::KIND_INT, 32'h7fff_ffff, 32'h8000_0001,
                                      0, 1, 1, -1, 1, 0));
        table_rows.push_back(make_row(KIND_BAD, 32'd9, 32'd4, 32'd3, 32'd5, 1, 0, 1, 0));
        table_rows.push_back(make_row(KIND_BAD, 32'hffff_ffff, 32'hffff_ffff,
                                      32'hffff_ffff, 32'hffff_ffff, 1, 0, 1, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_item(table_rows[i]);

        // Random items, with stretches where neither side pauses.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            it.kind = $urandom_range(0, 7);
            it.a_num = pick_value();
            it.a_den = pick_value();
            it.b_num = pick_value();
            it.b_den = pick_value();
            it.typed = 1'b0;
            send_item(it);
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b1;

        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (700) @(posedge clk);

        if (errors == 0 && answers_due.size() == 0)
            $display("PASS rational_arith_unit");
        else
            $display("FAIL rational_arith_unit");
        $finish;
    end

endmodule
